@@ rtl/zfba_pkg.sv @@
package zfba_pkg;

  // Block dimensions.
  localparam int unsigned ZONES           = 2;
  localparam int unsigned FRAMES_PER_ZONE = 1024;
  localparam int unsigned PAGE_BYTES      = 4096;
  localparam int unsigned PAGE_SHIFT      = $clog2(PAGE_BYTES);

  // Fixed field widths.
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned CNT_W      = 11;
  localparam int unsigned NF_W       = 11;
  localparam int unsigned OPC_W      = 2;
  localparam int unsigned ST_W       = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // Bitmap organization: one word of frame bits per memory entry.
  localparam int unsigned WORD_BITS      = (FRAMES_PER_ZONE < 32) ? FRAMES_PER_ZONE : 32;
  localparam int unsigned BIT_AW         = $clog2(WORD_BITS);
  localparam int unsigned WORDS_PER_ZONE = FRAMES_PER_ZONE / WORD_BITS;
  localparam int unsigned WORD_AW        = (WORDS_PER_ZONE > 1) ? $clog2(WORDS_PER_ZONE) : 1;
  localparam int unsigned MEM_WORDS      = ZONES * WORDS_PER_ZONE;
  localparam int unsigned MEM_AW         = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam int unsigned ZONE_AW        = (ZONES > 1) ? $clog2(ZONES) : 1;
  localparam int unsigned FRAME_W        = $clog2(FRAMES_PER_ZONE);
  localparam int unsigned NFC_W          = FRAME_W + 1;
  localparam int unsigned RUN_W          = ((NFC_W > CNT_W) ? NFC_W : CNT_W) + 1;

  // Odd register indexes hold a frame count, even ones a base address.
  localparam logic CFG_SEL_FRAMES = 1'b1;

  typedef enum logic [OPC_W-1:0] {
    OP_ALLOC_ANY = 2'd0,
    OP_ALLOC_AT  = 2'd1,
    OP_FREE      = 2'd2
  } opcode_e;

  typedef enum logic [ST_W-1:0] {
    ST_DONE   = 2'd0,
    ST_FAIL   = 2'd1,
    ST_NOZONE = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ZONE,
    S_SCAN,
    S_CHECK,
    S_MARK,
    S_RESP
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic zone_next;
    logic st_fail;
    logic scan_begin;
    logic range_at;
    logic range_free;
    logic step;
    logic scan_hit;
    logic check_ok;
    logic mark_step;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [OPC_W-1:0] op;
    logic             present;
    logic             holds;
    logic             fits;
    logic             cnt_zero;
    logic             zone_last;
    logic             scan_hit;
    logic             scan_end;
    logic             check_busy;
    logic             check_end;
    logic             mark_end;
  } dp_sts_t;

endpackage

@@ rtl/zfba_bitmap.sv @@
module zfba_bitmap (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                rd_en_i,
  input  logic [zfba_pkg::MEM_AW-1:0]         rd_addr_i,
  output logic [zfba_pkg::WORD_BITS-1:0]      rd_data_o,
  input  logic                                wr_en_i,
  input  logic [zfba_pkg::MEM_AW-1:0]         wr_addr_i,
  input  logic [zfba_pkg::WORD_BITS-1:0]      wr_mask_i,
  input  logic                                wr_val_i
);

  logic [zfba_pkg::WORD_BITS-1:0] mem [zfba_pkg::MEM_WORDS];
  logic [zfba_pkg::MEM_WORDS-1:0] vld_q;
  logic [zfba_pkg::WORD_BITS-1:0] rdata_q;
  logic                           rvld_q;

  // Bit-enabled write; the first write to a word fills its other bits with zero.
  always_ff @(posedge clk_i) begin
    for (int b = 0; b < zfba_pkg::WORD_BITS; b++) begin
      if (wr_en_i && (wr_mask_i[b] || !vld_q[wr_addr_i])) begin
        mem[wr_addr_i][b] <= wr_val_i & wr_mask_i[b];
      end
    end
  end

  // A word never written reads as all free.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_en_i) begin
      vld_q[wr_addr_i] <= 1'b1;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rdata_q <= mem[rd_addr_i];
      rvld_q  <= vld_q[rd_addr_i];
    end
  end

  assign rd_data_o = rvld_q ? rdata_q : '0;

endmodule

@@ rtl/zfba_dp.sv @@
module zfba_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [zfba_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [zfba_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic [zfba_pkg::OPC_W-1:0]         opcode_i,
  input  logic [zfba_pkg::ADDR_W-1:0]        address_i,
  input  logic [zfba_pkg::CNT_W-1:0]         count_i,
  input  zfba_pkg::dp_cmd_t                  cmd_i,
  output zfba_pkg::dp_sts_t                  sts_o,
  output logic [zfba_pkg::ADDR_W-1:0]        result_address_o,
  output logic [zfba_pkg::ST_W-1:0]          status_o
);

  localparam int unsigned AW  = zfba_pkg::ADDR_W;
  localparam int unsigned RW  = zfba_pkg::RUN_W;
  localparam int unsigned WB  = zfba_pkg::WORD_BITS;
  localparam int unsigned WAW = zfba_pkg::WORD_AW;
  localparam int unsigned NW  = zfba_pkg::NFC_W;

  // Configuration registers.
  logic [AW-1:0]               zone_base_q   [zfba_pkg::ZONES];
  logic [zfba_pkg::NF_W-1:0]   zone_frames_q [zfba_pkg::ZONES];
  logic [zfba_pkg::CFG_IDX_W-2:0] cfg_zone;

  // Request and working registers.
  logic [zfba_pkg::OPC_W-1:0]   op_q;
  logic [AW-1:0]                addr_q;
  logic [zfba_pkg::CNT_W-1:0]   cnt_q;
  logic [zfba_pkg::ZONE_AW-1:0] zone_q;
  logic [WAW-1:0]               ptr_q;
  logic [WAW-1:0]               rword_q;
  logic [RW-1:0]                carry_q;
  logic [RW-1:0]                lo_q;
  logic [RW-1:0]                hi_q;
  logic                         val_q;
  logic [AW-1:0]                res_q;
  zfba_pkg::status_e            st_q;

  // Zone evaluation.
  logic [AW-1:0]                   base_z;
  logic [zfba_pkg::NF_W-1:0]       nf_raw;
  logic [NW-1:0]                   nfc;
  logic [AW:0]                     lim;
  logic                            holds;
  logic [AW-1:0]                   diff;
  logic [zfba_pkg::FRAME_W-1:0]    idx;
  logic [RW-1:0]                   at_end;
  logic [NW-1:0]                   room;
  logic [RW-1:0]                   ncl;
  logic [RW-1:0]                   free_end;
  logic [WAW-1:0]                  last_zone_word;
  logic [WAW-1:0]                  w_last;

  // Word scan.
  logic [WB-1:0]                   rdata;
  logic [WB-1:0]                   used;
  logic [RW-1:0]                   run [WB];
  logic                            hit_any;
  logic [zfba_pkg::BIT_AW-1:0]     hit_b;
  logic [RW-1:0]                   hit_end;
  logic [RW-1:0]                   hit_lo;

  // Bitmap ports.
  logic                            rd_en;
  logic [WAW-1:0]                  rd_word;
  logic [zfba_pkg::MEM_AW-1:0]     rd_addr;
  logic [zfba_pkg::MEM_AW-1:0]     wr_addr;
  logic [WB-1:0]                   wr_mask;

  // Bits of one bitmap word that fall into the frame range [lo, hi).
  function automatic logic [WB-1:0] range_mask(input logic [WAW-1:0] w,
                                               input logic [RW-1:0] lo,
                                               input logic [RW-1:0] hi);
    logic [WB-1:0] m;
    logic [RW-1:0] f;
    for (int b = 0; b < WB; b++) begin
      f    = (RW'(w) << zfba_pkg::BIT_AW) + RW'(b);
      m[b] = (f >= lo) && (f < hi);
    end
    return m;
  endfunction

  // Configuration writes.
  assign cfg_zone = cfg_index_i[zfba_pkg::CFG_IDX_W-1:1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int z = 0; z < zfba_pkg::ZONES; z++) begin
        zone_base_q[z]   <= '0;
        zone_frames_q[z] <= '0;
      end
    end else if (cfg_we_i && (int'(cfg_zone) < zfba_pkg::ZONES)) begin
      if (cfg_index_i[0] == zfba_pkg::CFG_SEL_FRAMES) begin
        zone_frames_q[zfba_pkg::ZONE_AW'(cfg_zone)] <= cfg_data_i[zfba_pkg::NF_W-1:0];
      end else begin
        zone_base_q[zfba_pkg::ZONE_AW'(cfg_zone)] <= cfg_data_i[AW-1:0];
      end
    end
  end

  // Extent of the current zone and the frame range of the request in it.
  always_comb begin
    base_z   = zone_base_q[zone_q];
    nf_raw   = zone_frames_q[zone_q];
    nfc      = (int'(nf_raw) > zfba_pkg::FRAMES_PER_ZONE) ?
               NW'(zfba_pkg::FRAMES_PER_ZONE) : NW'(nf_raw);
    lim      = (AW+1)'(base_z) + ((AW+1)'(nfc) << zfba_pkg::PAGE_SHIFT);
    holds    = ({1'b0, addr_q} >= {1'b0, base_z}) && ({1'b0, addr_q} < lim);
    diff     = addr_q - base_z;
    idx      = diff[zfba_pkg::PAGE_SHIFT +: zfba_pkg::FRAME_W];
    at_end   = RW'(idx) + RW'(cnt_q);
    room     = nfc - NW'(idx);
    ncl      = (RW'(cnt_q) > RW'(room)) ? RW'(room) : RW'(cnt_q);
    free_end = RW'(idx) + ncl;
    last_zone_word = WAW'((nfc - NW'(1)) >> zfba_pkg::BIT_AW);
    w_last   = WAW'((hi_q - RW'(1)) >> zfba_pkg::BIT_AW);
  end

  // Free-run lengths ending at each bit of the word just read.
  always_comb begin
    logic          lfound;
    int unsigned   lpos;
    logic [RW-1:0] f;
    for (int b = 0; b < WB; b++) begin
      f       = (RW'(rword_q) << zfba_pkg::BIT_AW) + RW'(b);
      used[b] = rdata[b] | (f >= RW'(nfc));
    end
    for (int b = 0; b < WB; b++) begin
      lfound = 1'b0;
      lpos   = 0;
      for (int k = 0; k < WB; k++) begin
        if (k <= b && used[k]) begin
          lfound = 1'b1;
          lpos   = k;
        end
      end
      run[b] = lfound ? RW'(b - lpos) : carry_q + RW'(b + 1);
    end
    hit_any = 1'b0;
    hit_b   = '0;
    for (int b = WB - 1; b >= 0; b--) begin
      if (!used[b] && (run[b] >= RW'(cnt_q))) begin
        hit_any = 1'b1;
        hit_b   = zfba_pkg::BIT_AW'(b);
      end
    end
    hit_end = (RW'(rword_q) << zfba_pkg::BIT_AW) + RW'(hit_b);
    hit_lo  = hit_end + RW'(1) - RW'(cnt_q);
  end

  // Status toward the controller.
  always_comb begin
    sts_o.op         = op_q;
    sts_o.present    = (nfc != '0);
    sts_o.holds      = holds;
    sts_o.fits       = (cnt_q != '0) && (at_end <= RW'(nfc));
    sts_o.cnt_zero   = (cnt_q == '0);
    sts_o.zone_last  = (zone_q == zfba_pkg::ZONE_AW'(zfba_pkg::ZONES - 1));
    sts_o.scan_hit   = hit_any;
    sts_o.scan_end   = (rword_q == last_zone_word);
    sts_o.check_busy = |(rdata & range_mask(rword_q, lo_q, hi_q));
    sts_o.check_end  = (rword_q == w_last);
    sts_o.mark_end   = (ptr_q == w_last);
  end

  // Bitmap read and write addressing.
  always_comb begin
    rd_en   = cmd_i.scan_begin | cmd_i.range_at | cmd_i.step;
    rd_word = ptr_q;
    if (cmd_i.scan_begin) begin
      rd_word = '0;
    end else if (cmd_i.range_at) begin
      rd_word = WAW'(RW'(idx) >> zfba_pkg::BIT_AW);
    end
    rd_addr = zfba_pkg::MEM_AW'(zone_q) * zfba_pkg::MEM_AW'(zfba_pkg::WORDS_PER_ZONE)
            + zfba_pkg::MEM_AW'(rd_word);
    wr_addr = zfba_pkg::MEM_AW'(zone_q) * zfba_pkg::MEM_AW'(zfba_pkg::WORDS_PER_ZONE)
            + zfba_pkg::MEM_AW'(ptr_q);
    wr_mask = range_mask(ptr_q, lo_q, hi_q);
  end

  zfba_bitmap u_bitmap (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rdata),
    .wr_en_i   (cmd_i.mark_step),
    .wr_addr_i (wr_addr),
    .wr_mask_i (wr_mask),
    .wr_val_i  (val_q)
  );

  // Request registers and scan pointers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= opcode_i;
      addr_q <= address_i;
      cnt_q  <= count_i;
    end
    if (rd_en) begin
      rword_q <= rd_word;
    end
    if (cmd_i.scan_begin) begin
      ptr_q   <= WAW'(1);
      carry_q <= '0;
    end else if (cmd_i.range_at) begin
      lo_q  <= RW'(idx);
      hi_q  <= at_end;
      ptr_q <= rd_word + WAW'(1);
    end else if (cmd_i.range_free) begin
      lo_q  <= RW'(idx);
      hi_q  <= free_end;
      ptr_q <= WAW'(RW'(idx) >> zfba_pkg::BIT_AW);
      val_q <= 1'b0;
    end else if (cmd_i.scan_hit) begin
      lo_q  <= hit_lo;
      hi_q  <= hit_end + RW'(1);
      ptr_q <= WAW'(hit_lo >> zfba_pkg::BIT_AW);
      val_q <= 1'b1;
    end else if (cmd_i.check_ok) begin
      ptr_q <= WAW'(lo_q >> zfba_pkg::BIT_AW);
      val_q <= 1'b1;
    end else if (cmd_i.step) begin
      ptr_q   <= ptr_q + WAW'(1);
      carry_q <= run[WB-1];
    end else if (cmd_i.mark_step) begin
      ptr_q <= ptr_q + WAW'(1);
    end
  end

  // Zone index, result and status.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zone_q <= '0;
      res_q  <= '0;
      st_q   <= zfba_pkg::ST_FAIL;
    end else begin
      if (cmd_i.load) begin
        zone_q <= '0;
        res_q  <= '0;
        st_q   <= (opcode_i == zfba_pkg::OP_ALLOC_AT || opcode_i == zfba_pkg::OP_FREE) ?
                  zfba_pkg::ST_NOZONE : zfba_pkg::ST_FAIL;
      end else begin
        if (cmd_i.zone_next) begin
          zone_q <= zone_q + zfba_pkg::ZONE_AW'(1);
        end
        if (cmd_i.st_fail) begin
          st_q <= zfba_pkg::ST_FAIL;
        end
        if (cmd_i.range_free) begin
          st_q <= zfba_pkg::ST_DONE;
        end
        if (cmd_i.scan_hit) begin
          res_q <= base_z + (AW'(hit_lo) << zfba_pkg::PAGE_SHIFT);
          st_q  <= zfba_pkg::ST_DONE;
        end
        if (cmd_i.check_ok) begin
          res_q <= addr_q;
          st_q  <= zfba_pkg::ST_DONE;
        end
      end
    end
  end

  assign result_address_o = res_q;
  assign status_o         = st_q;

  // A marking pass only runs over a non-empty range.
  a_mark_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mark_step |-> (hi_q > lo_q))
    else $error("bitmap write with an empty frame range");

  // A found run always reports success.
  a_hit_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_hit |=> (st_q == zfba_pkg::ST_DONE))
    else $error("found run did not report success");

endmodule

@@ rtl/zfba_ctrl.sv @@
module zfba_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  zfba_pkg::dp_sts_t sts_i,
  output zfba_pkg::dp_cmd_t cmd_o,
  output logic              done_o,
  output logic              busy_o
);

  zfba_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= zfba_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      zfba_pkg::S_IDLE: begin
        if (start_i) state_d = zfba_pkg::S_ZONE;
      end
      zfba_pkg::S_ZONE: begin
        case (sts_i.op)
          zfba_pkg::OP_ALLOC_ANY: begin
            if (!sts_i.present) state_d = zfba_pkg::S_RESP;
            else if (!sts_i.cnt_zero) state_d = zfba_pkg::S_SCAN;
            else if (sts_i.zone_last) state_d = zfba_pkg::S_RESP;
          end
          zfba_pkg::OP_ALLOC_AT: begin
            if (sts_i.holds && sts_i.fits) state_d = zfba_pkg::S_CHECK;
            else if (sts_i.zone_last) state_d = zfba_pkg::S_RESP;
          end
          zfba_pkg::OP_FREE: begin
            if (!sts_i.present) state_d = zfba_pkg::S_RESP;
            else if (sts_i.holds) begin
              state_d = sts_i.cnt_zero ? zfba_pkg::S_RESP : zfba_pkg::S_MARK;
            end else if (sts_i.zone_last) state_d = zfba_pkg::S_RESP;
          end
          default: state_d = zfba_pkg::S_RESP;
        endcase
      end
      zfba_pkg::S_SCAN: begin
        if (sts_i.scan_hit) state_d = zfba_pkg::S_MARK;
        else if (sts_i.scan_end) begin
          state_d = sts_i.zone_last ? zfba_pkg::S_RESP : zfba_pkg::S_ZONE;
        end
      end
      zfba_pkg::S_CHECK: begin
        if (sts_i.check_busy) begin
          state_d = sts_i.zone_last ? zfba_pkg::S_RESP : zfba_pkg::S_ZONE;
        end else if (sts_i.check_end) state_d = zfba_pkg::S_MARK;
      end
      zfba_pkg::S_MARK: begin
        if (sts_i.mark_end) state_d = zfba_pkg::S_RESP;
      end
      zfba_pkg::S_RESP: state_d = zfba_pkg::S_IDLE;
      default: state_d = zfba_pkg::S_IDLE;
    endcase
  end

  // Datapath commands.
  always_comb begin
    cmd_o = '0;
    case (state_q)
      zfba_pkg::S_IDLE: cmd_o.load = start_i;
      zfba_pkg::S_ZONE: begin
        case (sts_i.op)
          zfba_pkg::OP_ALLOC_ANY: begin
            if (sts_i.present) begin
              if (sts_i.cnt_zero) cmd_o.zone_next = !sts_i.zone_last;
              else cmd_o.scan_begin = 1'b1;
            end
          end
          zfba_pkg::OP_ALLOC_AT: begin
            if (!sts_i.holds) cmd_o.zone_next = !sts_i.zone_last;
            else begin
              cmd_o.st_fail = 1'b1;
              if (sts_i.fits) cmd_o.range_at = 1'b1;
              else cmd_o.zone_next = !sts_i.zone_last;
            end
          end
          zfba_pkg::OP_FREE: begin
            if (sts_i.present) begin
              if (sts_i.holds) cmd_o.range_free = 1'b1;
              else cmd_o.zone_next = !sts_i.zone_last;
            end
          end
          default: ;
        endcase
      end
      zfba_pkg::S_SCAN: begin
        if (sts_i.scan_hit) cmd_o.scan_hit = 1'b1;
        else if (sts_i.scan_end) cmd_o.zone_next = !sts_i.zone_last;
        else cmd_o.step = 1'b1;
      end
      zfba_pkg::S_CHECK: begin
        if (sts_i.check_busy) cmd_o.zone_next = !sts_i.zone_last;
        else if (sts_i.check_end) cmd_o.check_ok = 1'b1;
        else cmd_o.step = 1'b1;
      end
      zfba_pkg::S_MARK: cmd_o.mark_step = 1'b1;
      default: ;
    endcase
  end

  assign done_o = (state_q == zfba_pkg::S_RESP);
  assign busy_o = (state_q != zfba_pkg::S_IDLE);

  // The result strobe lasts one cycle and frees the block.
  a_resp_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_o)
    else $error("result strobe not followed by idle");

  // An accepted request always starts with a zone check.
  a_start_zone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (state_q == zfba_pkg::S_ZONE))
    else $error("accepted request did not enter the zone check");

endmodule

@@ rtl/zoned_frame_bitmap_allocator_unit.sv @@
// A request walks the zones in order until a zone check settles it; a scan or check reads
// one 32-frame bitmap word at a time (up to 64 words over two zones) through the single
// read port of the bitmap memory, and marking writes one word at a time.
// The block takes one request at a time; the next is taken the cycle after the strobe.
// Reset clears the zone registers and per-word valid bits, so every frame is free
// at once; the result receiver cannot stall.
module zoned_frame_bitmap_allocator_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [zfba_pkg::OPC_W-1:0]      opcode_i,
  input  logic [zfba_pkg::ADDR_W-1:0]     address_i,
  input  logic [zfba_pkg::CNT_W-1:0]      count_i,
  output logic                            done_o,
  output logic [zfba_pkg::ADDR_W-1:0]     result_address_o,
  output logic [zfba_pkg::ST_W-1:0]       status_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [zfba_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [zfba_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  zfba_pkg::dp_cmd_t cmd;
  zfba_pkg::dp_sts_t sts;

  // Configuration transactions complete at once.
  assign cfg_ready_o = 1'b1;

  zfba_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .done_o  (done_o),
    .busy_o  (busy)
  );

  zfba_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_valid_i & cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .opcode_i         (opcode_i),
    .address_i        (address_i),
    .count_i          (count_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .result_address_o (result_address_o),
    .status_o         (status_o)
  );

endmodule

@@ bench/zfba_checker.sv @@
`timescale 1ns / 100ps

module zfba_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic                            busy_i,
  input  logic [zfba_pkg::OPC_W-1:0]      opcode_i,
  input  logic [zfba_pkg::ADDR_W-1:0]     address_i,
  input  logic [zfba_pkg::CNT_W-1:0]      count_i,
  input  logic                            done_i,
  input  logic [zfba_pkg::ADDR_W-1:0]     result_address_i,
  input  logic [zfba_pkg::ST_W-1:0]       status_i,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [zfba_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [zfba_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                              fail_count_o,
  output int                              pending_o
);

  typedef struct packed {
    logic [zfba_pkg::ADDR_W-1:0] addr;
    zfba_pkg::status_e           status;
  } alloc_result_t;

  logic [zfba_pkg::ADDR_W-1:0] zone_base   [zfba_pkg::ZONES];
  logic [zfba_pkg::NF_W-1:0]   zone_frames [zfba_pkg::ZONES];
  logic                        frame_used  [zfba_pkg::ZONES * zfba_pkg::FRAMES_PER_ZONE];
  alloc_result_t               expected_q  [$];

  assign pending_o = expected_q.size();

  // Usable frames of a zone: counts above the zone size are clamped.
  function automatic int unsigned usable_frames(int z);
    return (zone_frames[z] > zfba_pkg::FRAMES_PER_ZONE) ?
           zfba_pkg::FRAMES_PER_ZONE : zone_frames[z];
  endfunction

  // The zone extent is compared at 64 bits, so it never wraps.
  function automatic bit zone_covers(int z, logic [zfba_pkg::ADDR_W-1:0] a);
    longint unsigned lo, hi;
    lo = zone_base[z];
    hi = lo + longint'(usable_frames(z)) * zfba_pkg::PAGE_BYTES;
    return (a >= lo) && (a < hi);
  endfunction

  function automatic void set_run(int z, int unsigned idx, int unsigned n, logic v);
    for (int unsigned i = 0; i < n; i++)
      frame_used[z * zfba_pkg::FRAMES_PER_ZONE + idx + i] = v;
  endfunction

  // Applies one request to the frame map and returns the answer it earns.
  function automatic alloc_result_t serve_request(logic [zfba_pkg::OPC_W-1:0] op,
                                                  logic [zfba_pkg::ADDR_W-1:0] a,
                                                  logic [zfba_pkg::CNT_W-1:0] cnt);
    alloc_result_t r;
    int unsigned   nf, run, idx, n;
    bit            hit, clear;
    r.addr   = '0;
    r.status = zfba_pkg::ST_FAIL;
    case (op)
      zfba_pkg::OP_ALLOC_ANY: begin
        for (int z = 0; z < zfba_pkg::ZONES; z++) begin
          nf = usable_frames(z);
          if (nf == 0) break;
          if (cnt == 0) continue;
          run = 0;
          hit = 0;
          for (int unsigned i = 0; i < nf; i++) begin
            if (frame_used[z * zfba_pkg::FRAMES_PER_ZONE + i]) begin
              run = 0;
            end else begin
              run++;
              if (run == cnt) begin
                idx = i + 1 - cnt;
                hit = 1;
                break;
              end
            end
          end
          if (hit) begin
            set_run(z, idx, cnt, 1'b1);
            r.addr   = zone_base[z] + idx * zfba_pkg::PAGE_BYTES;
            r.status = zfba_pkg::ST_DONE;
            break;
          end
        end
      end
      zfba_pkg::OP_ALLOC_AT: begin
        r.status = zfba_pkg::ST_NOZONE;
        for (int z = 0; z < zfba_pkg::ZONES; z++) begin
          if (!zone_covers(z, a)) continue;
          r.status = zfba_pkg::ST_FAIL;
          idx = (a - zone_base[z]) / zfba_pkg::PAGE_BYTES;
          if (cnt == 0 || idx + cnt > usable_frames(z)) continue;
          clear = 1;
          for (int unsigned i = 0; i < cnt; i++)
            if (frame_used[z * zfba_pkg::FRAMES_PER_ZONE + idx + i]) clear = 0;
          if (clear) begin
            set_run(z, idx, cnt, 1'b1);
            r.addr   = a;
            r.status = zfba_pkg::ST_DONE;
            break;
          end
        end
      end
      zfba_pkg::OP_FREE: begin
        r.status = zfba_pkg::ST_NOZONE;
        for (int z = 0; z < zfba_pkg::ZONES; z++) begin
          nf = usable_frames(z);
          if (nf == 0) break;
          if (!zone_covers(z, a)) continue;
          idx = (a - zone_base[z]) / zfba_pkg::PAGE_BYTES;
          n   = (cnt > nf - idx) ? nf - idx : cnt;
          set_run(z, idx, n, 1'b0);
          r.status = zfba_pkg::ST_DONE;
          break;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Track register writes, predict accepted requests and compare results.
  always @(posedge clk_i) begin
    alloc_result_t want;
    if (!rst_ni) begin
      for (int z = 0; z < zfba_pkg::ZONES; z++) begin
        zone_base[z]   = '0;
        zone_frames[z] = '0;
      end
      for (int i = 0; i < zfba_pkg::ZONES * zfba_pkg::FRAMES_PER_ZONE; i++)
        frame_used[i] = 1'b0;
      expected_q.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i && (cfg_index_i >> 1) < zfba_pkg::ZONES) begin
        if (cfg_index_i[0] == zfba_pkg::CFG_SEL_FRAMES)
          zone_frames[cfg_index_i >> 1] = cfg_data_i[zfba_pkg::NF_W-1:0];
        else
          zone_base[cfg_index_i >> 1] = cfg_data_i;
      end
      if (start_i && !busy_i)
        expected_q.push_back(serve_request(opcode_i, address_i, count_i));
      if (done_i) begin
        if (expected_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("%0t: result with nothing outstanding: addr %h status %0d",
                     $realtime, result_address_i, status_i);
        end else begin
          want = expected_q.pop_front();
          if (result_address_i !== want.addr || status_i !== want.status) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("%0t: mismatch: expected addr %h status %0d, got addr %h status %0d",
                       $realtime, want.addr, want.status, result_address_i, status_i);
          end
        end
      end
    end
  end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

  localparam logic [zfba_pkg::OPC_W-1:0]     OP_UNUSED        = 2'd3;
  localparam logic [zfba_pkg::CFG_IDX_W-1:0] REG_ZONE0_BASE   = 2'd0;
  localparam logic [zfba_pkg::CFG_IDX_W-1:0] REG_ZONE0_FRAMES = 2'd1;
  localparam logic [zfba_pkg::CFG_IDX_W-1:0] REG_ZONE1_BASE   = 2'd2;
  localparam logic [zfba_pkg::CFG_IDX_W-1:0] REG_ZONE1_FRAMES = 2'd3;
  localparam int RANDOM_ITEMS = 2000;
  localparam int PHASES       = 8;
  localparam int CYCLE_LIMIT  = 1500000;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            start = 1'b0;
  logic                            busy;
  logic [zfba_pkg::OPC_W-1:0]      opcode_i = '0;
  logic [zfba_pkg::ADDR_W-1:0]     address_i = '0;
  logic [zfba_pkg::CNT_W-1:0]      count_i = '0;
  logic                            done_o;
  logic [zfba_pkg::ADDR_W-1:0]     result_address_o;
  logic [zfba_pkg::ST_W-1:0]       status_o;
  logic                            cfg_valid_i = 1'b0;
  logic                            cfg_ready_o;
  logic [zfba_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [zfba_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;
  int                              fail_count;
  int                              pending;
  int                              cycles = 0;

  // Zone layout as last written, used only to aim addresses into zones.
  logic [zfba_pkg::ADDR_W-1:0] cur_base   [zfba_pkg::ZONES];
  int unsigned                 cur_frames [zfba_pkg::ZONES];

  always #2 clk_i = ~clk_i;

  zoned_frame_bitmap_allocator_unit u_top (
    .clk_i, .rst_ni, .start, .busy, .opcode_i, .address_i, .count_i,
    .done_o, .result_address_o, .status_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  zfba_checker u_checker (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .opcode_i, .address_i, .count_i,
    .done_i(done_o), .result_address_i(result_address_o), .status_i(status_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // One register transaction; the caller makes sure the block is idle.
  task automatic write_reg(logic [zfba_pkg::CFG_IDX_W-1:0] idx,
                           logic [zfba_pkg::CFG_DATA_W-1:0] data);
    bit ok;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do begin
      #1 ok = cfg_ready_o;
      @(negedge clk_i);
    end while (!ok);
    cfg_valid_i <= 1'b0;
    if (idx[0] == zfba_pkg::CFG_SEL_FRAMES)
      cur_frames[idx >> 1] = (data[zfba_pkg::NF_W-1:0] > zfba_pkg::FRAMES_PER_ZONE) ?
                             zfba_pkg::FRAMES_PER_ZONE : data[zfba_pkg::NF_W-1:0];
    else
      cur_base[idx >> 1] = data;
  endtask

  // Waits for all answers, lets the block settle, then sets both zones.
  task automatic set_zones(logic [31:0] b0, logic [31:0] f0, logic [31:0] b1,
                           logic [31:0] f1);
    start <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    write_reg(REG_ZONE0_BASE, b0);
    write_reg(REG_ZONE0_FRAMES, f0);
    write_reg(REG_ZONE1_BASE, b1);
    write_reg(REG_ZONE1_FRAMES, f1);
  endtask

  // Presents one request and holds start until the block takes it.
  task automatic send_request(logic [zfba_pkg::OPC_W-1:0] op,
                              logic [zfba_pkg::ADDR_W-1:0] a,
                              logic [zfba_pkg::CNT_W-1:0] cnt);
    bit ok;
    start     <= 1'b1;
    opcode_i  <= op;
    address_i <= a;
    count_i   <= cnt;
    do begin
      #1 ok = !busy;
      @(negedge clk_i);
    end while (!ok);
  endtask

  // Random gap after a transaction; none while the steady stretch runs.
  task automatic idle_gap(bit steady);
    if (!steady && $urandom_range(0, 99) < 23) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
  endtask

  // An address inside a present zone most of the time, anything otherwise.
  function automatic logic [zfba_pkg::ADDR_W-1:0] pick_address();
    int z;
    longint unsigned a;
    z = $urandom_range(0, zfba_pkg::ZONES - 1);
    if ($urandom_range(0, 99) < 15 || cur_frames[z] == 0) return $urandom;
    a = longint'(cur_base[z]) +
        longint'($urandom_range(0, cur_frames[z] - 1)) * zfba_pkg::PAGE_BYTES;
    if (a >= 64'h1_0000_0000) a = cur_base[z];
    if ($urandom_range(0, 3) == 0) a += $urandom_range(1, zfba_pkg::PAGE_BYTES - 1);
    return (a >= 64'h1_0000_0000) ? cur_base[z] : a[zfba_pkg::ADDR_W-1:0];
  endfunction

  function automatic logic [zfba_pkg::CNT_W-1:0] pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return zfba_pkg::CNT_W'($urandom_range(1, 8));
    if (r < 90) return zfba_pkg::CNT_W'($urandom_range(1, 64));
    if (r < 98) return zfba_pkg::CNT_W'($urandom);
    return '0;
  endfunction

  function automatic logic [zfba_pkg::OPC_W-1:0] pick_opcode();
    int r;
    r = $urandom_range(0, 99);
    if (r < 38) return zfba_pkg::OP_ALLOC_ANY;
    if (r < 63) return zfba_pkg::OP_ALLOC_AT;
    if (r < 95) return zfba_pkg::OP_FREE;
    return OP_UNUSED;
  endfunction

  initial begin
    int n;
    for (int z = 0; z < zfba_pkg::ZONES; z++) begin
      cur_base[z]   = '0;
      cur_frames[z] = 0;
    end
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: zones absent after reset.
    send_request(zfba_pkg::OP_ALLOC_ANY, '0, 11'd1);
    send_request(zfba_pkg::OP_FREE, '0, 11'd1);
    send_request(zfba_pkg::OP_ALLOC_AT, 32'hFFFF_FFFF, 11'h7FF);

    // Directed: a tiny zone zero and a full-size zone one.
    set_zones(32'h1000_0000, 32'd8, 32'h2000_0000, 32'hFFFF_F800 | 32'd1024);
    send_request(zfba_pkg::OP_ALLOC_ANY, '0, 11'd0);
    send_request(zfba_pkg::OP_ALLOC_ANY, '0, 11'd1);
    send_request(zfba_pkg::OP_ALLOC_AT, 32'h1000_0000, 11'd1);
    send_request(zfba_pkg::OP_ALLOC_AT, 32'h1000_1ABC, 11'd2);
    send_request(zfba_pkg::OP_ALLOC_AT, 32'h1000_6000, 11'd3);
    send_request(zfba_pkg::OP_ALLOC_AT, 32'h1000_7000, 11'd0);
    send_request(zfba_pkg::OP_ALLOC_ANY, '0, 11'd8);
    send_request(zfba_pkg::OP_ALLOC_ANY, '0, 11'd1024);
    send_request(zfba_pkg::OP_ALLOC_ANY, '0, 11'd1);
    send_request(zfba_pkg::OP_ALLOC_ANY, '0, 11'h7FF);
    send_request(zfba_pkg::OP_FREE, 32'h1000_2000, 11'h7FF);
    send_request(zfba_pkg::OP_FREE, 32'h2000_0000, 11'd0);
    send_request(zfba_pkg::OP_FREE, 32'hFFFF_FFFF, 11'd4);
    send_request(zfba_pkg::OP_ALLOC_AT, 32'h3000_0000, 11'd1);
    send_request(OP_UNUSED, 32'hFFFF_FFFF, 11'h7FF);
    send_request(zfba_pkg::OP_FREE, 32'h2000_0000, 11'd1024);
    send_request(zfba_pkg::OP_ALLOC_ANY, '0, 11'd9);

    // Random phases, each with its own zone layout.
    n = 0;
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: set_zones(32'h0, 32'd32, 32'h0004_0000, 32'd64);
        1: set_zones(32'hFFFF_0000, 32'h7FF, 32'h0, 32'd16);
        2: set_zones(32'h0, 32'd0, 32'h0000_1000, 32'd40);
        3: set_zones(32'h0010_0000, 32'd16, 32'h0010_8000, 32'd24);
        4: set_zones(32'h0, 32'd1024, 32'h0040_0000, 32'd1024);
        default: set_zones($urandom & 32'hFFFF_F000, $urandom_range(0, 48),
                           $urandom, $urandom_range(1, 48) | ($urandom & 32'hFFFF_F800));
      endcase
      for (int i = 0; i < RANDOM_ITEMS / PHASES; i++) begin
        send_request(pick_opcode(), pick_address(), pick_count());
        n++;
        if (n == RANDOM_ITEMS / 3) begin
          start <= 1'b0;
          while (pending != 0) @(negedge clk_i);
        end else begin
          idle_gap(n > 1000 && n < 1200);
        end
      end
    end
    start <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (fail_count == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

endmodule
